/* rtl/core/pspt_pkg.sv */
// ----------------------------------------------------------------------------
// pspt_pkg: shared types and constants of the priority ordered slot table
// Transfer payloads, operation and status codes, compare results.
// ----------------------------------------------------------------------------
package pspt_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int NAME_BYTES_DEF = 48;
  localparam int NAME_WORDS     = 6;

  // "free" in little endian byte order, terminator follows.
  localparam logic [31:0] FREE_WORD = 32'h6565_7266;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_FIND   = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_EMPTY  = 3'd3;
  localparam logic [2:0] OP_GET    = 3'd4;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND  = 2'd1;
  localparam logic [1:0] STAT_NO_FREE    = 2'd2;
  localparam logic [1:0] STAT_NOT_PLACED = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic [31:0]        stream_id;
    logic signed [31:0] priority_req;
    logic [31:0]        handler;
    logic [31:0]        volume;
    logic [63:0]        name_word0;
    logic [63:0]        name_word1;
    logic [63:0]        name_word2;
    logic [63:0]        name_word3;
    logic [63:0]        name_word4;
    logic [63:0]        name_word5;
    logic [3:0]         position;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         slot_index;
    logic [31:0]        found_id;
    logic signed [31:0] found_priority;
    logic [31:0]        found_handler;
    logic [31:0]        found_volume;
    logic               list_changed;
  } out_t;

  typedef struct packed {
    logic id_eq;
    logic id_zero;
    logic name_eq;
    logic lower;
  } cmp_res_t;

endpackage

/* rtl/core/pspt_name_mem.sv */
// ----------------------------------------------------------------------------
// pspt_name_mem: stream name storage
// One row per slot, registered read. Rows never written since the last clear
// read back as the free name.
// ----------------------------------------------------------------------------
module pspt_name_mem #(
  parameter int SLOTS      = pspt_pkg::SLOTS_DEF,
  parameter int NAME_BYTES = pspt_pkg::NAME_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [$clog2(SLOTS)-1:0]  wr_addr_i,
  input  logic [NAME_BYTES*8-1:0]   wr_data_i,
  input  logic [SLOTS-1:0]          clr_rows_i,
  input  logic [$clog2(SLOTS)-1:0]  rd_addr_i,
  output logic [NAME_BYTES*8-1:0]   rd_data_o
);
  import pspt_pkg::*;

  localparam int NBW = NAME_BYTES * 8;
  localparam logic [NBW-1:0] FREE_NAME = NBW'(FREE_WORD);

  logic [NBW-1:0] mem_q [SLOTS];
  logic [NBW-1:0] rd_data_q;
  logic [SLOTS-1:0] vld_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q    <= (vld_q & ~clr_rows_i) | (wr_en_i ? (SLOTS'(1) << wr_addr_i) : '0);
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : FREE_NAME;

endmodule

/* rtl/core/pspt_order.sv */
// ----------------------------------------------------------------------------
// pspt_order: list order of the physical slots
// Holds the permutation and moves one slot to a new position on each move.
// ----------------------------------------------------------------------------
module pspt_order #(
  parameter int SLOTS = pspt_pkg::SLOTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      init_i,
  input  logic                      move_i,
  input  logic [$clog2(SLOTS)-1:0]  move_from_i,
  input  logic [$clog2(SLOTS)-1:0]  move_to_i,
  input  logic [$clog2(SLOTS)-1:0]  move_slot_i,
  input  logic [$clog2(SLOTS)-1:0]  rd_pos_i,
  output logic [$clog2(SLOTS)-1:0]  rd_slot_o
);
  import pspt_pkg::*;

  localparam int SW = $clog2(SLOTS);

  logic [SW-1:0] ord_q [SLOTS];
  logic [SW-1:0] ord_d [SLOTS];

  always_comb begin
    int fi;
    int pi;
    fi = int'(move_from_i);
    pi = int'(move_to_i);
    for (int k = 0; k < SLOTS; k++) begin
      ord_d[k] = ord_q[k];
      if (init_i) begin
        ord_d[k] = SW'(k);
      end else if (move_i) begin
        if (fi > pi) begin
          // Entries between the target and the old place slide one back.
          if (k == pi) begin
            ord_d[k] = move_slot_i;
          end else if (k > pi && k <= fi) begin
            ord_d[k] = ord_q[(k == 0) ? 0 : k - 1];
          end
        end else if (fi + 1 < pi) begin
          // The slot lands just in front of the lower entry.
          if (k == pi - 1) begin
            ord_d[k] = move_slot_i;
          end else if (k >= fi && k + 1 < pi) begin
            ord_d[k] = ord_q[(k == SLOTS - 1) ? k : k + 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        ord_q[k] <= SW'(k);
      end
    end else begin
      ord_q <= ord_d;
    end
  end

  assign rd_slot_o = ord_q[rd_pos_i];

endmodule

/* rtl/core/pspt_cmp.sv */
// ----------------------------------------------------------------------------
// pspt_cmp: slot compare unit
// Compares one stored slot against the request: id, name and priority.
// ----------------------------------------------------------------------------
module pspt_cmp #(
  parameter int NAME_BYTES = pspt_pkg::NAME_BYTES_DEF
) (
  input  logic [31:0]               st_id_i,
  input  logic signed [31:0]        st_prio_i,
  input  logic [NAME_BYTES*8-1:0]   st_name_i,
  input  logic [31:0]               rq_id_i,
  input  logic signed [31:0]        rq_prio_i,
  input  logic [NAME_BYTES*8-1:0]   rq_name_i,
  output pspt_pkg::cmp_res_t        res_o
);
  import pspt_pkg::*;

  // Both names are zero padded after their terminator, so a plain equality
  // over the whole row matches string comparison.
  always_comb begin
    res_o.id_eq   = (st_id_i == rq_id_i);
    res_o.id_zero = (st_id_i == 32'd0);
    res_o.name_eq = (st_name_i == rq_name_i);
    res_o.lower   = (st_prio_i < rq_prio_i);
  end

endmodule

/* rtl/core/priority_ordered_stream_slot_table.sv */
// ----------------------------------------------------------------------------
// priority_ordered_stream_slot_table: stream slots kept in priority order
// Sequencer, slot registers and scan pipeline around one compare unit.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the in channel (valid/ready) and each one yields exactly
// one result on the out channel (valid/ready). One command is worked at a
// time; in_ready_o is high only while the sequencer is idle.
// Insert, and a find or remove that misses, scan the whole list one position
// per cycle through the single compare unit behind the registered slot and
// name read. A find or remove that matches ends its scan early. Empty and
// undefined codes go straight to the finishing state; get first reads the
// slot at the requested position.
// A new command can be taken as soon as the previous result appears.
// The result sits in an output register; a stalled receiver holds it there
// and a new command may be taken meanwhile, finishing only once the output
// register is free again.
// Reset gives slot_count 16 (at most SLOTS), all slots free and named "free",
// identity order and a cleared changed flag. A write on the configuration
// port sets slot_count and does the same clear; it must come only while idle,
// which the block itself does not enforce.
// ----------------------------------------------------------------------------
module priority_ordered_stream_slot_table #(
  parameter int SLOTS      = pspt_pkg::SLOTS_DEF,
  parameter int NAME_BYTES = pspt_pkg::NAME_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pspt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pspt_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [4:0]     cfg_wdata_i
);
  import pspt_pkg::*;

  localparam int SW     = $clog2(SLOTS);
  localparam int CW     = $clog2(SLOTS + 1);
  localparam int NBW    = NAME_BYTES * 8;
  localparam int PXW    = SW + 4;
  localparam int CNTRST = (16 > SLOTS) ? SLOTS : 16;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_GET  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  in_t            req_q;
  logic [NBW-1:0] rq_name_q;
  logic [NBW-1:0] in_name;

  logic [CW-1:0] count_q;
  logic [CW-1:0] cfg_count;
  logic          changed_q, changed_d;

  logic [31:0]        ent_id_q   [SLOTS];
  logic signed [31:0] ent_prio_q [SLOTS];
  logic [31:0]        ent_hdl_q  [SLOTS];
  logic [31:0]        ent_vol_q  [SLOTS];

  logic [CW-1:0] p_q;
  logic          p_ok;

  logic               s1_vld_q;
  logic [CW-1:0]      s1_pos_q;
  logic [SW-1:0]      s1_slot_q;
  logic [31:0]        s1_id_q;
  logic signed [31:0] s1_prio_q;
  logic [31:0]        s1_hdl_q;
  logic [31:0]        s1_vol_q;
  logic [NBW-1:0]     s1_name;

  logic               cand_q;
  logic [CW-1:0]      cand_pos_q;
  logic [SW-1:0]      cand_slot_q;
  logic [31:0]        cand_id_q;
  logic signed [31:0] cand_prio_q;
  logic [31:0]        cand_hdl_q;
  logic [31:0]        cand_vol_q;
  logic               have_lower_q;
  logic [CW-1:0]      lower_pos_q;

  logic [PXW-1:0] pos_ext;
  logic           pos_ok;
  logic [SW-1:0]  ord_rd_pos;
  logic [SW-1:0]  rd_slot;

  cmp_res_t cmp;
  logic     hit;
  logic     scan_end;

  out_t res_d, res_q, out_q;
  logic out_vld_q;
  logic out_free;

  logic accept;
  logic fin;
  logic ins_wr;
  logic rm_clr;
  logic emp_clr;
  logic chg_set;
  logic [SLOTS-1:0] clr_rows;

  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign fin      = (state_q == S_FIN);
  assign out_free = !out_vld_q || out_ready_i;

  // Request name cut to its terminator and to the stored length.
  always_comb begin
    logic [383:0]           flat;
    logic [NAME_BYTES-1:0]  zb;
    logic [NAME_BYTES-1:0]  low;
    flat = {in_data_i.name_word5, in_data_i.name_word4, in_data_i.name_word3,
            in_data_i.name_word2, in_data_i.name_word1, in_data_i.name_word0};
    for (int i = 0; i < NAME_BYTES; i++) begin
      zb[i] = (flat[8*i +: 8] == 8'd0);
    end
    for (int i = 0; i < NAME_BYTES; i++) begin
      low = (NAME_BYTES'(1) << i) - NAME_BYTES'(1);
      in_name[8*i +: 8] = (|(zb & low)) ? 8'd0 : flat[8*i +: 8];
    end
  end

  always_comb begin
    int cv;
    cv = int'(cfg_wdata_i);
    if (cv == 0) begin
      cfg_count = CW'(1);
    end else if (cv > SLOTS) begin
      cfg_count = CW'(SLOTS);
    end else begin
      cfg_count = CW'(cv);
    end
  end

  assign p_ok    = (p_q < count_q);
  assign pos_ext = PXW'(req_q.position);
  assign pos_ok  = (pos_ext < PXW'(count_q));

  always_comb begin
    if (state_q == S_SCAN) begin
      ord_rd_pos = p_ok ? p_q[SW-1:0] : '0;
    end else begin
      ord_rd_pos = pos_ok ? pos_ext[SW-1:0] : '0;
    end
  end

  pspt_order #(
    .SLOTS(SLOTS)
  ) u_order (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (cfg_we_i),
    .move_i     (fin && ins_wr),
    .move_from_i(cand_pos_q[SW-1:0]),
    .move_to_i  (lower_pos_q[SW-1:0]),
    .move_slot_i(cand_slot_q),
    .rd_pos_i   (ord_rd_pos),
    .rd_slot_o  (rd_slot)
  );

  pspt_name_mem #(
    .SLOTS     (SLOTS),
    .NAME_BYTES(NAME_BYTES)
  ) u_name_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fin && ins_wr),
    .wr_addr_i (cand_slot_q),
    .wr_data_i (rq_name_q),
    .clr_rows_i(clr_rows),
    .rd_addr_i (rd_slot),
    .rd_data_o (s1_name)
  );

  pspt_cmp #(
    .NAME_BYTES(NAME_BYTES)
  ) u_cmp (
    .st_id_i  (s1_id_q),
    .st_prio_i(s1_prio_q),
    .st_name_i(s1_name),
    .rq_id_i  (req_q.stream_id),
    .rq_prio_i(req_q.priority_req),
    .rq_name_i(rq_name_q),
    .res_o    (cmp)
  );

  assign hit      = s1_vld_q && cmp.id_eq && cmp.name_eq;
  assign scan_end = !p_ok && !s1_vld_q;

  // Result and table updates of the finishing cycle.
  always_comb begin
    res_d   = '0;
    ins_wr  = 1'b0;
    rm_clr  = 1'b0;
    emp_clr = 1'b0;
    chg_set = 1'b0;
    unique case (req_q.op)
      OP_INSERT: begin
        if (!cand_q) begin
          res_d.status = STAT_NO_FREE;
        end else if (!have_lower_q) begin
          res_d.status         = STAT_NOT_PLACED;
          res_d.slot_index     = 4'(cand_slot_q);
          res_d.found_id       = cand_id_q;
          res_d.found_priority = cand_prio_q;
          res_d.found_handler  = cand_hdl_q;
          res_d.found_volume   = cand_vol_q;
        end else begin
          ins_wr               = 1'b1;
          chg_set              = 1'b1;
          res_d.status         = STAT_OK;
          res_d.slot_index     = 4'(cand_slot_q);
          res_d.found_id       = req_q.stream_id;
          res_d.found_priority = req_q.priority_req;
          res_d.found_handler  = req_q.handler;
          res_d.found_volume   = req_q.volume;
        end
      end
      OP_FIND, OP_REMOVE: begin
        if (cand_q) begin
          rm_clr               = (req_q.op == OP_REMOVE);
          chg_set              = (req_q.op == OP_REMOVE);
          res_d.status         = STAT_OK;
          res_d.slot_index     = 4'(cand_slot_q);
          res_d.found_id       = cand_id_q;
          res_d.found_priority = cand_prio_q;
          res_d.found_handler  = cand_hdl_q;
          res_d.found_volume   = cand_vol_q;
        end else begin
          res_d.status = STAT_NOT_FOUND;
        end
      end
      OP_EMPTY: begin
        emp_clr      = 1'b1;
        chg_set      = 1'b1;
        res_d.status = STAT_OK;
      end
      OP_GET: begin
        if (pos_ok) begin
          res_d.status         = STAT_OK;
          res_d.slot_index     = 4'(s1_slot_q);
          res_d.found_id       = s1_id_q;
          res_d.found_priority = s1_prio_q;
          res_d.found_handler  = s1_hdl_q;
          res_d.found_volume   = s1_vol_q;
        end else begin
          res_d.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        res_d.status = STAT_NOT_FOUND;
      end
    endcase
    res_d.list_changed = changed_q || chg_set;
  end

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      clr_rows[k] = cfg_we_i
                 || (fin && emp_clr && (CW'(k) < count_q))
                 || (fin && rm_clr && (cand_slot_q == SW'(k)));
    end
  end

  always_comb begin
    if (cfg_we_i) begin
      changed_d = 1'b0;
    end else if (fin && chg_set) begin
      changed_d = 1'b1;
    end else begin
      changed_d = changed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        ent_id_q[k]   <= '0;
        ent_prio_q[k] <= '0;
        ent_hdl_q[k]  <= '0;
        ent_vol_q[k]  <= '0;
      end
      count_q   <= CW'(CNTRST);
      changed_q <= 1'b0;
    end else begin
      for (int k = 0; k < SLOTS; k++) begin
        if (clr_rows[k]) begin
          ent_id_q[k]   <= '0;
          ent_prio_q[k] <= '0;
          ent_hdl_q[k]  <= '0;
          ent_vol_q[k]  <= '0;
        end
      end
      if (fin && ins_wr) begin
        ent_id_q[cand_slot_q]   <= req_q.stream_id;
        ent_prio_q[cand_slot_q] <= req_q.priority_req;
        ent_hdl_q[cand_slot_q]  <= req_q.handler;
        ent_vol_q[cand_slot_q]  <= req_q.volume;
      end
      if (cfg_we_i) begin
        count_q <= cfg_count;
      end
      changed_q <= changed_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.op)
            OP_INSERT, OP_FIND, OP_REMOVE: state_d = S_SCAN;
            OP_GET:                        state_d = S_GET;
            default:                       state_d = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if ((req_q.op != OP_INSERT && hit) || scan_end) begin
          state_d = S_FIN;
        end
      end
      S_GET:  state_d = S_FIN;
      S_FIN:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      p_q          <= '0;
      s1_vld_q     <= 1'b0;
      cand_q       <= 1'b0;
      have_lower_q <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        p_q          <= '0;
        s1_vld_q     <= 1'b0;
        cand_q       <= 1'b0;
        have_lower_q <= 1'b0;
      end else begin
        s1_vld_q <= (state_q == S_SCAN) && p_ok;
        if (state_q == S_SCAN) begin
          if (p_ok) begin
            p_q <= p_q + CW'(1);
          end
          if (req_q.op == OP_INSERT) begin
            if (s1_vld_q && !cand_q && cmp.id_zero) begin
              cand_q <= 1'b1;
            end
            if (s1_vld_q && !have_lower_q && cmp.lower) begin
              have_lower_q <= 1'b1;
            end
          end else if (hit) begin
            cand_q <= 1'b1;
          end
        end
      end
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= in_data_i;
      rq_name_q <= in_name;
    end
    s1_pos_q  <= p_q;
    s1_slot_q <= rd_slot;
    s1_id_q   <= ent_id_q[rd_slot];
    s1_prio_q <= ent_prio_q[rd_slot];
    s1_hdl_q  <= ent_hdl_q[rd_slot];
    s1_vol_q  <= ent_vol_q[rd_slot];
    if (state_q == S_SCAN && s1_vld_q && !cand_q &&
        ((req_q.op == OP_INSERT && cmp.id_zero) ||
         (req_q.op != OP_INSERT && cmp.id_eq && cmp.name_eq))) begin
      cand_pos_q  <= s1_pos_q;
      cand_slot_q <= s1_slot_q;
      cand_id_q   <= s1_id_q;
      cand_prio_q <= s1_prio_q;
      cand_hdl_q  <= s1_hdl_q;
      cand_vol_q  <= s1_vol_q;
    end
    if (state_q == S_SCAN && s1_vld_q && !have_lower_q && cmp.lower) begin
      lower_pos_q <= s1_pos_q;
    end
    if (fin) begin
      res_q <= res_d;
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
